>>> src/rget_pkg.sv
// Shared constants, types and control structs for the range-gated echo tracker.
package rget_pkg;

   localparam int MAX_TRACKS = 16;
   localparam int IDX_W      = (MAX_TRACKS > 1) ? $clog2(MAX_TRACKS) : 1;
   localparam int CNT_W      = $clog2(MAX_TRACKS + 1);

   localparam int RANGE_W    = 8;
   localparam int AMP_W      = 8;
   localparam int LIFE_W     = 8;
   localparam int ID_W       = 32;
   localparam int BEARING_W  = 9;
   localparam int DROP_W     = 8;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 9;

   localparam logic [LIFE_W-1:0] LIFE_STEP = LIFE_W'(2);
   localparam logic [DROP_W-1:0] DROP_MAX  = '1;

   localparam logic [AMP_W-1:0]     AMP_THRESHOLD_RST = AMP_W'(10);
   localparam logic [RANGE_W-1:0]   RANGE_MIN_RST     = RANGE_W'(15);
   localparam logic [RANGE_W-1:0]   RANGE_MAX_RST     = RANGE_W'(250);
   localparam logic [RANGE_W-1:0]   MATCH_WINDOW_RST  = RANGE_W'(20);
   localparam logic [LIFE_W-1:0]    LIFETIME_CAP_RST  = LIFE_W'(20);
   localparam logic [BEARING_W-1:0] BEARING_RST       = '0;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_AMP_THRESHOLD = 3'd0,
      CSR_RANGE_MIN     = 3'd1,
      CSR_RANGE_MAX     = 3'd2,
      CSR_MATCH_WINDOW  = 3'd3,
      CSR_LIFETIME_CAP  = 3'd4,
      CSR_BEARING       = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic [RANGE_W-1:0] range;
      logic [LIFE_W-1:0]  life;
      logic [ID_W-1:0]    ident;
      logic               matched;
      logic               active;
   } trk_entry_type;

   typedef struct packed {
      logic                 report_valid;
      logic [ID_W-1:0]      report_id;
      logic [RANGE_W-1:0]   report_range;
      logic [BEARING_W-1:0] report_bearing;
      logic [DROP_W-1:0]    dropped_points;
      logic                 last_report;
   } report_type;

   typedef struct packed {
      logic load_req;
      logic scan_clr;
      logic scan_inc;
      logic pt_update;
      logic pt_append;
      logic pt_drop;
      logic fr_step;
      logic fr_final;
   } dp_cmd_type;

   typedef struct packed {
      logic gate_pass;
      logic scan_end;
      logic hit;
      logic table_full;
      logic entry_active;
      logic pend_valid;
      logic out_free;
   } dp_status_type;

endpackage

>>> src/range_gated_echo_tracker.sv
// Top level of the range-gated echo tracker: controller plus datapath.
// Usage:
//  - req_ channel: one transfer per echo point (req_command 0) or end of frame
//    (req_command 1). Accepted when req_valid is high and req_stall is low.
//  - rsp_ channel: one transfer per active track at end of frame, or a single
//    report with rsp_report_valid low when none is active; rsp_last_report marks
//    the final transfer of the frame. Echo points produce no transfer.
//  - csr_ port: register writes take effect on the edge where csr_write_enable
//    is high; write only while the block is idle.
// Timing: an echo point that passes the gate is compared with the stored tracks
// by a serial scan that examines one track entry per cycle. An end of frame
// sweeps the table one entry per cycle while the receiver does not hold it up;
// the first report appears once the second active track is found or the sweep
// ends. req_stall stays high while an item is in work.
// A stalled result sits in the output register; the sweep waits only when it
// needs to hand over another report and the register is still occupied.
// Reset: synchronous, active high; the table is empty, the ID and drop counters
// are zero and settings return to defaults; data registers are not reset.
module range_gated_echo_tracker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_command,
   input  logic [rget_pkg::RANGE_W-1:0]        req_echo_range,
   input  logic [rget_pkg::AMP_W-1:0]          req_echo_amplitude,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic                                rsp_report_valid,
   output logic [rget_pkg::ID_W-1:0]           rsp_report_id,
   output logic [rget_pkg::RANGE_W-1:0]        rsp_report_range,
   output logic [rget_pkg::BEARING_W-1:0]      rsp_report_bearing,
   output logic [rget_pkg::DROP_W-1:0]         rsp_dropped_points,
   output logic                                rsp_last_report,
   input  logic                                csr_write_enable,
   input  logic [rget_pkg::CSR_ADDR_W-1:0]     csr_index,
   input  logic [rget_pkg::CSR_DATA_W-1:0]     csr_write_data
);
   import rget_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   rget_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_command (req_command),
      .req_stall   (req_stall),
      .status      (status),
      .cmd         (cmd)
   );

   rget_dpath u_dpath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .req_echo_range     (req_echo_range),
      .req_echo_amplitude (req_echo_amplitude),
      .csr_write_enable   (csr_write_enable),
      .csr_index          (csr_index),
      .csr_write_data     (csr_write_data),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_report_valid   (rsp_report_valid),
      .rsp_report_id      (rsp_report_id),
      .rsp_report_range   (rsp_report_range),
      .rsp_report_bearing (rsp_report_bearing),
      .rsp_dropped_points (rsp_dropped_points),
      .rsp_last_report    (rsp_last_report)
   );

endmodule

>>> src/rget_ctrl.sv
// Controller state machine: sequences point scans and end-of-frame sweeps.
module rget_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_command,
   output logic                   req_stall,
   input  rget_pkg::dp_status_type status,
   output rget_pkg::dp_cmd_type    cmd
);
   import rget_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_PSCAN = 4'b0010,
      ST_FSCAN = 4'b0100,
      ST_FLAST = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load_req = 1'b1;
               cmd.scan_clr = 1'b1;
               state_in     = req_command ? ST_FSCAN : ST_PSCAN;
            end
         end
         ST_PSCAN: begin
            if (!status.gate_pass) begin
               state_in = ST_IDLE;
            end else if (status.scan_end) begin
               if (status.table_full) begin
                  cmd.pt_drop = 1'b1;
               end else begin
                  cmd.pt_append = 1'b1;
               end
               state_in = ST_IDLE;
            end else if (status.hit) begin
               cmd.pt_update = 1'b1;
               state_in      = ST_IDLE;
            end else begin
               cmd.scan_inc = 1'b1;
            end
         end
         ST_FSCAN: begin
            if (status.scan_end) begin
               state_in = ST_FLAST;
            end else if (!(status.entry_active && status.pend_valid) || status.out_free) begin
               cmd.fr_step = 1'b1;
            end
         end
         ST_FLAST: begin
            if (status.out_free) begin
               cmd.fr_final = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

>>> src/rget_dpath.sv
// Datapath: settings, track table, scan counters, pending report and output register.
module rget_dpath (
   input  logic                                clock,
   input  logic                                reset,
   input  rget_pkg::dp_cmd_type                cmd,
   output rget_pkg::dp_status_type             status,
   input  logic [rget_pkg::RANGE_W-1:0]        req_echo_range,
   input  logic [rget_pkg::AMP_W-1:0]          req_echo_amplitude,
   input  logic                                csr_write_enable,
   input  logic [rget_pkg::CSR_ADDR_W-1:0]     csr_index,
   input  logic [rget_pkg::CSR_DATA_W-1:0]     csr_write_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic                                rsp_report_valid,
   output logic [rget_pkg::ID_W-1:0]           rsp_report_id,
   output logic [rget_pkg::RANGE_W-1:0]        rsp_report_range,
   output logic [rget_pkg::BEARING_W-1:0]      rsp_report_bearing,
   output logic [rget_pkg::DROP_W-1:0]         rsp_dropped_points,
   output logic                                rsp_last_report
);
   import rget_pkg::*;

   logic [AMP_W-1:0]     amp_threshold_ff;
   logic [RANGE_W-1:0]   range_min_ff, range_max_ff, match_window_ff;
   logic [LIFE_W-1:0]    lifetime_cap_ff;
   logic [BEARING_W-1:0] bearing_ff;

   logic [RANGE_W-1:0]   pt_range_ff, pt_range_in;
   logic [AMP_W-1:0]     pt_amp_ff, pt_amp_in;
   logic [CNT_W-1:0]     rd_ff, rd_in, wr_ff, wr_in, count_ff, count_in;
   logic [ID_W-1:0]      next_ident_ff, next_ident_in;
   logic [DROP_W-1:0]    drop_ff, drop_in;
   logic                 pend_valid_ff, pend_valid_in;
   logic [ID_W-1:0]      pend_id_ff, pend_id_in;
   logic [RANGE_W-1:0]   pend_range_ff, pend_range_in;
   logic                 out_valid_ff, out_valid_in;
   report_type           out_ff, out_in;
   trk_entry_type        trk_ff [MAX_TRACKS];

   trk_entry_type        entry, wr_data;
   logic                 wr_en;
   logic [IDX_W-1:0]     wr_idx;
   logic [RANGE_W-1:0]   diff;
   logic [LIFE_W-1:0]    cap_eff, life_dec;
   logic [LIFE_W:0]      life_sum;
   logic                 over;
   logic [ID_W-1:0]      id_inc, id_new;
   logic                 push;
   report_type           push_data;

   assign entry    = trk_ff[rd_ff[IDX_W-1:0]];
   assign diff     = (entry.range > pt_range_ff) ? (entry.range - pt_range_ff)
                                                 : (pt_range_ff - entry.range);
   assign cap_eff  = (lifetime_cap_ff == '0) ? LIFE_W'(1) : lifetime_cap_ff;
   assign life_sum = {1'b0, entry.life} + {1'b0, LIFE_STEP};
   assign over     = life_sum > {1'b0, cap_eff};
   assign life_dec = entry.life - LIFE_W'(1);
   assign id_inc   = next_ident_ff + ID_W'(1);
   assign id_new   = (id_inc == '0) ? ID_W'(1) : id_inc;

   assign status.gate_pass    = (pt_amp_ff > amp_threshold_ff) && (pt_range_ff > range_min_ff)
                                && (pt_range_ff < range_max_ff);
   assign status.scan_end     = rd_ff == count_ff;
   assign status.hit          = !entry.matched && (diff <= match_window_ff);
   assign status.table_full   = count_ff >= CNT_W'(MAX_TRACKS);
   assign status.entry_active = entry.active;
   assign status.pend_valid   = pend_valid_ff;
   assign status.out_free     = !out_valid_ff || !rsp_stall;

   always_comb begin
      pt_range_in   = pt_range_ff;
      pt_amp_in     = pt_amp_ff;
      rd_in         = rd_ff;
      wr_in         = wr_ff;
      count_in      = count_ff;
      next_ident_in = next_ident_ff;
      drop_in       = drop_ff;
      pend_valid_in = pend_valid_ff;
      pend_id_in    = pend_id_ff;
      pend_range_in = pend_range_ff;
      wr_en         = 1'b0;
      wr_idx        = rd_ff[IDX_W-1:0];
      wr_data       = entry;
      push          = 1'b0;
      push_data     = '0;

      if (cmd.load_req) begin
         pt_range_in = req_echo_range;
         pt_amp_in   = req_echo_amplitude;
      end
      if (cmd.scan_clr) begin
         rd_in = '0;
         wr_in = '0;
      end
      if (cmd.scan_inc) begin
         rd_in = rd_ff + CNT_W'(1);
      end

      if (cmd.pt_update) begin
         wr_en           = 1'b1;
         wr_data.range   = pt_range_ff;
         wr_data.matched = 1'b1;
         if (over) begin
            wr_data.life   = cap_eff;
            wr_data.active = 1'b1;
            if (entry.ident == '0) begin
               wr_data.ident = id_new;
               next_ident_in = id_new;
            end
         end else begin
            wr_data.life   = life_sum[LIFE_W-1:0];
            wr_data.active = 1'b0;
         end
      end

      if (cmd.pt_append) begin
         wr_en    = 1'b1;
         wr_idx   = count_ff[IDX_W-1:0];
         wr_data  = '{range: pt_range_ff, life: LIFE_STEP, ident: '0,
                      matched: 1'b1, active: 1'b0};
         count_in = count_ff + CNT_W'(1);
      end

      if (cmd.pt_drop && (drop_ff != DROP_MAX)) begin
         drop_in = drop_ff + DROP_W'(1);
      end

      if (cmd.fr_step) begin
         rd_in = rd_ff + CNT_W'(1);
         if (life_dec != '0) begin
            wr_en           = 1'b1;
            wr_idx          = wr_ff[IDX_W-1:0];
            wr_data.life    = life_dec;
            wr_data.matched = 1'b0;
            wr_in           = wr_ff + CNT_W'(1);
         end
         if (entry.active) begin
            if (pend_valid_ff) begin
               push      = 1'b1;
               push_data = '{report_valid: 1'b1, report_id: pend_id_ff,
                             report_range: pend_range_ff, report_bearing: bearing_ff,
                             dropped_points: drop_ff, last_report: 1'b0};
            end
            pend_valid_in = 1'b1;
            pend_id_in    = entry.ident;
            pend_range_in = entry.range;
         end
      end

      if (cmd.fr_final) begin
         push = 1'b1;
         if (pend_valid_ff) begin
            push_data = '{report_valid: 1'b1, report_id: pend_id_ff,
                          report_range: pend_range_ff, report_bearing: bearing_ff,
                          dropped_points: drop_ff, last_report: 1'b1};
         end else begin
            push_data = '{report_valid: 1'b0, report_id: '0, report_range: '0,
                          report_bearing: '0, dropped_points: drop_ff, last_report: 1'b1};
         end
         pend_valid_in = 1'b0;
         drop_in       = '0;
         count_in      = wr_ff;
      end

      out_valid_in = out_valid_ff && rsp_stall;
      out_in       = out_ff;
      if (push) begin
         out_valid_in = 1'b1;
         out_in       = push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         amp_threshold_ff <= AMP_THRESHOLD_RST;
         range_min_ff     <= RANGE_MIN_RST;
         range_max_ff     <= RANGE_MAX_RST;
         match_window_ff  <= MATCH_WINDOW_RST;
         lifetime_cap_ff  <= LIFETIME_CAP_RST;
         bearing_ff       <= BEARING_RST;
         rd_ff            <= '0;
         wr_ff            <= '0;
         count_ff         <= '0;
         next_ident_ff    <= '0;
         drop_ff          <= '0;
         pend_valid_ff    <= 1'b0;
         out_valid_ff     <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               CSR_AMP_THRESHOLD: amp_threshold_ff <= csr_write_data[AMP_W-1:0];
               CSR_RANGE_MIN:     range_min_ff     <= csr_write_data[RANGE_W-1:0];
               CSR_RANGE_MAX:     range_max_ff     <= csr_write_data[RANGE_W-1:0];
               CSR_MATCH_WINDOW:  match_window_ff  <= csr_write_data[RANGE_W-1:0];
               CSR_LIFETIME_CAP:  lifetime_cap_ff  <= csr_write_data[LIFE_W-1:0];
               CSR_BEARING:       bearing_ff       <= csr_write_data[BEARING_W-1:0];
               default: begin
               end
            endcase
         end
         rd_ff         <= rd_in;
         wr_ff         <= wr_in;
         count_ff      <= count_in;
         next_ident_ff <= next_ident_in;
         drop_ff       <= drop_in;
         pend_valid_ff <= pend_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pt_range_ff   <= pt_range_in;
      pt_amp_ff     <= pt_amp_in;
      pend_id_ff    <= pend_id_in;
      pend_range_ff <= pend_range_in;
      out_ff        <= out_in;
      if (wr_en) begin
         trk_ff[wr_idx] <= wr_data;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_report_valid   = out_ff.report_valid;
   assign rsp_report_id      = out_ff.report_id;
   assign rsp_report_range   = out_ff.report_range;
   assign rsp_report_bearing = out_ff.report_bearing;
   assign rsp_dropped_points = out_ff.dropped_points;
   assign rsp_last_report    = out_ff.last_report;

endmodule

>>> bench/echo_track_board_pkg.sv
// Scoreboard class: tracker prediction and in-order checking of report transfers.
package echo_track_board_pkg;
   import rget_pkg::*;

   class echo_track_board;
      bit [AMP_W-1:0]     amp_thr;
      bit [RANGE_W-1:0]   gate_lo;
      bit [RANGE_W-1:0]   gate_hi;
      bit [RANGE_W-1:0]   window;
      bit [LIFE_W-1:0]    life_cap;
      bit [BEARING_W-1:0] bearing;

      bit [RANGE_W-1:0]   trk_rng [MAX_TRACKS];
      bit [LIFE_W-1:0]    trk_lf  [MAX_TRACKS];
      bit [ID_W-1:0]      trk_id  [MAX_TRACKS];
      bit                 trk_hit [MAX_TRACKS];
      bit                 trk_on  [MAX_TRACKS];
      int                 n_trk;
      bit [ID_W-1:0]      last_id;
      bit [DROP_W-1:0]    drops;

      report_type         due_reports[$];
      int                 errors;

      function new();
         amp_thr  = AMP_THRESHOLD_RST;
         gate_lo  = RANGE_MIN_RST;
         gate_hi  = RANGE_MAX_RST;
         window   = MATCH_WINDOW_RST;
         life_cap = LIFETIME_CAP_RST;
         bearing  = BEARING_RST;
         n_trk    = 0;
         last_id  = '0;
         drops    = '0;
         errors   = 0;
      endfunction

      function void apply_reg(csr_index_type idx, bit [CSR_DATA_W-1:0] val);
         case (idx)
            CSR_AMP_THRESHOLD: amp_thr  = val[AMP_W-1:0];
            CSR_RANGE_MIN:     gate_lo  = val[RANGE_W-1:0];
            CSR_RANGE_MAX:     gate_hi  = val[RANGE_W-1:0];
            CSR_MATCH_WINDOW:  window   = val[RANGE_W-1:0];
            CSR_LIFETIME_CAP:  life_cap = val[LIFE_W-1:0];
            CSR_BEARING:       bearing  = val[BEARING_W-1:0];
            default: ;
         endcase
      endfunction

      function void gate_and_associate(bit [RANGE_W-1:0] r, bit [AMP_W-1:0] a);
         int eff_cap;
         int diff;
         int sum;
         int i;
         eff_cap = (life_cap == 0) ? 1 : int'(life_cap);
         if (!(a > amp_thr && r > gate_lo && r < gate_hi))
            return;
         for (i = 0; i < n_trk; i++) begin
            diff = (trk_rng[i] > r) ? int'(trk_rng[i]) - int'(r) : int'(r) - int'(trk_rng[i]);
            if (diff <= int'(window) && !trk_hit[i]) begin
               sum = int'(trk_lf[i]) + int'(LIFE_STEP);
               trk_hit[i] = 1'b1;
               trk_rng[i] = r;
               if (sum > eff_cap) begin
                  trk_lf[i] = LIFE_W'(eff_cap);
                  if (trk_id[i] == 0) begin
                     last_id = last_id + 1'b1;
                     if (last_id == 0)
                        last_id = 1;
                     trk_id[i] = last_id;
                  end
                  trk_on[i] = 1'b1;
               end else begin
                  trk_lf[i] = LIFE_W'(sum);
                  trk_on[i] = 1'b0;
               end
               return;
            end
         end
         if (n_trk >= MAX_TRACKS) begin
            if (drops != DROP_MAX)
               drops = drops + 1'b1;
            return;
         end
         trk_rng[n_trk] = r;
         trk_lf[n_trk]  = LIFE_STEP;
         trk_id[n_trk]  = '0;
         trk_hit[n_trk] = 1'b1;
         trk_on[n_trk]  = 1'b0;
         n_trk++;
      endfunction

      // Ages the table and queues the frame's reports; a removed entry's successor is visited in the same slot.
      function void age_and_report();
         report_type frame_reps[$];
         report_type rep;
         int i;
         int j;
         i = 0;
         while (i < n_trk) begin
            trk_lf[i]  = trk_lf[i] - 1'b1;
            trk_hit[i] = 1'b0;
            if (trk_on[i]) begin
               rep = '0;
               rep.report_valid   = 1'b1;
               rep.report_id      = trk_id[i];
               rep.report_range   = trk_rng[i];
               rep.report_bearing = bearing;
               rep.dropped_points = drops;
               frame_reps = {frame_reps, rep};
            end
            if (trk_lf[i] == 0) begin
               for (j = i; j + 1 < n_trk; j++) begin
                  trk_rng[j] = trk_rng[j+1];
                  trk_lf[j]  = trk_lf[j+1];
                  trk_id[j]  = trk_id[j+1];
                  trk_hit[j] = trk_hit[j+1];
                  trk_on[j]  = trk_on[j+1];
               end
               n_trk--;
            end else begin
               i++;
            end
         end
         if (frame_reps.size() == 0) begin
            rep = '0;
            rep.dropped_points = drops;
            frame_reps = {frame_reps, rep};
         end
         rep = frame_reps.pop_back();
         rep.last_report = 1'b1;
         frame_reps = {frame_reps, rep};
         due_reports = {due_reports, frame_reps};
         drops = '0;
      endfunction

      function void note_transfer(bit cmd, bit [RANGE_W-1:0] r, bit [AMP_W-1:0] a);
         if (cmd)
            age_and_report();
         else
            gate_and_associate(r, a);
      endfunction

      task mismatch(string what);
         $display("MISMATCH: %s", what);
         errors++;
      endtask

      task check_report(report_type got);
         report_type want;
         if (due_reports.size() == 0) begin
            mismatch($sformatf("unexpected report transfer id=%0d range=%0d",
                               got.report_id, got.report_range));
            return;
         end
         want = due_reports.pop_front();
         if (got !== want)
            mismatch($sformatf({"got valid=%0b id=%0d range=%0d bearing=%0d drops=%0d last=%0b,",
                                " want valid=%0b id=%0d range=%0d bearing=%0d drops=%0d last=%0b"},
                               got.report_valid, got.report_id, got.report_range,
                               got.report_bearing, got.dropped_points, got.last_report,
                               want.report_valid, want.report_id, want.report_range,
                               want.report_bearing, want.dropped_points, want.last_report));
      endtask
   endclass

endpackage

>>> bench/tb_top.sv
// Testbench top: drives echo points and frame ends, checks track report transfers.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import rget_pkg::*;
   import echo_track_board_pkg::*;

   localparam int CYCLE_LIMIT   = 400000;
   localparam int SETTLE_CYCLES = 2 * MAX_TRACKS + 8;

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_stall;
   logic                   req_command;
   logic [RANGE_W-1:0]     req_echo_range;
   logic [AMP_W-1:0]       req_echo_amplitude;
   logic                   rsp_valid;
   logic                   rsp_stall;
   logic                   rsp_report_valid;
   logic [ID_W-1:0]        rsp_report_id;
   logic [RANGE_W-1:0]     rsp_report_range;
   logic [BEARING_W-1:0]   rsp_report_bearing;
   logic [DROP_W-1:0]      rsp_dropped_points;
   logic                   rsp_last_report;
   logic                   csr_write_enable;
   csr_index_type          csr_index;
   logic [CSR_DATA_W-1:0]  csr_write_data;

   echo_track_board board;
   int                    burst_left;
   int                    cycle_count;

   range_gated_echo_tracker dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_command        (req_command),
      .req_echo_range     (req_echo_range),
      .req_echo_amplitude (req_echo_amplitude),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_report_valid   (rsp_report_valid),
      .rsp_report_id      (rsp_report_id),
      .rsp_report_range   (rsp_report_range),
      .rsp_report_bearing (rsp_report_bearing),
      .rsp_dropped_points (rsp_dropped_points),
      .rsp_last_report    (rsp_last_report),
      .csr_write_enable   (csr_write_enable),
      .csr_index          (csr_index),
      .csr_write_data     (csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Verification failed");
      $finish;
   end

   // receiver stall pattern: stretches of fixed stall density, zero included
   initial begin
      int pct;
      int span;
      rsp_stall = 1'b0;
      forever begin
         case ($urandom_range(4))
            0, 1:    pct = 0;
            2:       pct = 30;
            3:       pct = 60;
            default: pct = 90;
         endcase
         span = $urandom_range(150, 10);
         repeat (span) begin
            @(negedge clock);
            rsp_stall = ($urandom_range(99) < pct);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         board.check_report({rsp_report_valid, rsp_report_id, rsp_report_range,
                             rsp_report_bearing, rsp_dropped_points, rsp_last_report});
   end

   task csr_write(csr_index_type idx, bit [CSR_DATA_W-1:0] val);
      @(negedge clock);
      csr_write_enable = 1'b1;
      csr_index        = idx;
      csr_write_data   = val;
      @(posedge clock);
      board.apply_reg(idx, val);
      @(negedge clock);
      csr_write_enable = 1'b0;
   endtask

   task load_setup(bit [CSR_DATA_W-1:0] thr, bit [CSR_DATA_W-1:0] lo,
                   bit [CSR_DATA_W-1:0] hi, bit [CSR_DATA_W-1:0] win,
                   bit [CSR_DATA_W-1:0] cap, bit [CSR_DATA_W-1:0] brg);
      csr_write(CSR_AMP_THRESHOLD, thr);
      csr_write(CSR_RANGE_MIN, lo);
      csr_write(CSR_RANGE_MAX, hi);
      csr_write(CSR_MATCH_WINDOW, win);
      csr_write(CSR_LIFETIME_CAP, cap);
      csr_write(CSR_BEARING, brg);
   endtask

   // one transfer on the req_ channel, inside bursts separated by random gaps
   task put_item(bit cmd, bit [RANGE_W-1:0] rng, bit [AMP_W-1:0] amp);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(24, 1);
         gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(12, 1);
         if (gap > 0) begin
            @(negedge clock);
            req_valid = 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end
      burst_left--;
      @(negedge clock);
      req_valid          = 1'b1;
      req_command        = cmd;
      req_echo_range     = rng;
      req_echo_amplitude = amp;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      board.note_transfer(cmd, rng, amp);
   endtask

   task settle();
      @(negedge clock);
      req_valid = 1'b0;
      while (board.due_reports.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // frames of echoes around persistent targets, plus noise and target turnover
   task run_phase(int quota);
      bit [RANGE_W-1:0] spots[$];
      int n_spots;
      int sent;
      int k;
      int reps;
      int half;
      int rv;
      int amp_i;
      int lo;
      int hi;
      lo = 0;
      hi = 255;
      if (int'(board.gate_lo) + 2 <= int'(board.gate_hi)) begin
         lo = int'(board.gate_lo) + 1;
         hi = int'(board.gate_hi) - 1;
      end
      half = int'(board.window) / 2;
      n_spots = $urandom_range(20, 1);
      for (k = 0; k < n_spots; k++)
         spots = {spots, RANGE_W'($urandom_range(hi, lo))};
      sent = 0;
      while (sent < quota) begin
         for (k = 0; k < n_spots; k++) begin
            reps = ($urandom_range(99) < 85) + ($urandom_range(99) < 12);
            repeat (reps) begin
               rv = int'(spots[k]) + int'($urandom_range(2 * half)) - half;
               rv = (rv < 0) ? 0 : (rv > 255) ? 255 : rv;
               if (board.amp_thr == DROP_MAX || $urandom_range(99) < 8)
                  amp_i = int'(board.amp_thr);
               else
                  amp_i = $urandom_range(255, int'(board.amp_thr) + 1);
               put_item(1'b0, RANGE_W'(rv), AMP_W'(amp_i));
               sent++;
            end
         end
         if ($urandom_range(99) < 20) begin
            put_item(1'b0, RANGE_W'($urandom), AMP_W'($urandom));
            sent++;
         end
         if ($urandom_range(99) < 15)
            spots[$urandom_range(n_spots - 1)] = RANGE_W'($urandom_range(hi, lo));
         put_item(1'b1, RANGE_W'($urandom), AMP_W'($urandom));
         sent++;
      end
   endtask

   initial begin
      board              = new();
      reset              = 1'b1;
      req_valid          = 1'b0;
      req_command        = 1'b0;
      req_echo_range     = '0;
      req_echo_amplitude = '0;
      csr_write_enable   = 1'b0;
      csr_index          = CSR_AMP_THRESHOLD;
      csr_write_data     = '0;
      burst_left         = 0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // zero cap acts as one; bearing beyond 359 passes through
      csr_write(CSR_LIFETIME_CAP, 9'd0);
      csr_write(CSR_BEARING, 9'd511);
      put_item(1'b0, 8'd16, 8'd11);
      put_item(1'b0, 8'd249, 8'd255);
      put_item(1'b0, 8'd250, 8'd200);
      put_item(1'b0, 8'd15, 8'd200);
      put_item(1'b0, 8'd100, 8'd10);
      put_item(1'b0, 8'd255, 8'd255);
      put_item(1'b0, 8'd0, 8'd0);
      put_item(1'b0, 8'd30, 8'd11);
      put_item(1'b1, 8'hFF, 8'hFF);
      put_item(1'b0, 8'd20, 8'd50);
      put_item(1'b0, 8'd36, 8'd50);
      // both actives expire; the inactive one between them is erased too
      put_item(1'b1, 8'h00, 8'h00);
      put_item(1'b1, 8'hA5, 8'h5A);
      settle();

      load_setup(9'd10, 9'd15, 9'd250, 9'd20, 9'd4, 9'd123);
      run_phase(110);
      settle();
      load_setup(9'd0, 9'd0, 9'd255, 9'd255, 9'd255, 9'd0);
      run_phase(90);
      settle();
      load_setup(9'd255, 9'd255, 9'd0, 9'd0, 9'd1, 9'd359);
      run_phase(30);
      settle();
      load_setup(9'd100, 9'd40, 9'd200, 9'd0, 9'd3, 9'd360);
      run_phase(90);
      settle();
      repeat (2) begin
         load_setup({1'($urandom), 8'($urandom_range(80))},
                    {1'($urandom), 8'($urandom_range(40))},
                    {1'($urandom), 8'($urandom_range(255, 180))},
                    {1'($urandom), 8'($urandom_range(40))},
                    {1'($urandom), 8'($urandom_range(8))},
                    9'($urandom_range(511)));
         run_phase(90);
         settle();
      end

      if (board.errors == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
